/* rtl/ria_pkg.sv */
// Package for the reference-counted identifier allocator.
// Holds the word types, operation and status codes, and the controller/datapath
// command and status structs. Depends on nothing.
package ria_pkg;

  // Fixed field widths of the request and response words
  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 16;

  // Defaults for the top-level parameters
  localparam int DEF_ID_BITS    = 8;
  localparam int DEF_COUNT_BITS = 16;

  // Operation codes (codes 5 to 7 are accepted and do nothing)
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INC   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEC   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  // Request word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } req_t;

  // Response word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     new_id;
    logic                present;
    logic [CNT_W-1:0]    ref_count;
    logic                is_full;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch request, read its entry
    logic exec;        // finish a non-scanning operation, load response
    logic scan_start;  // scan pointer from the freed lower bound
    logic scan_rd;     // read the entry at the scan pointer
    logic scan_next;   // advance the scan pointer
    logic scan_take;   // hand out the freed id at the scan pointer
    logic clr_start;   // restore registers, clear pointer to zero
    logic clr_wr;      // zero one entry, advance clear pointer
    logic clr_rsp;     // load the response of a clear-all
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alloc_freed;  // request is allocate and a freed id exists
    logic is_clear;     // request is clear-all
    logic scan_hit;     // entry read by the scan is freed
    logic clr_last;     // clear pointer is at the last entry
    logic out_free;     // response register can take a word this cycle
  } dp_status_t;

endpackage

/* rtl/ria_ctrl.sv */
// Controller of the identifier allocator: sequences request execution,
// freed-id scans and the entry clearing pass. Depends on ria_pkg.
module ria_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ria_pkg::dp_status_t    status_i,
  output ria_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    StClear,
    StClrRsp,
    StIdle,
    StExec,
    StScanRd,
    StScanChk
  } state_e;

  state_e state_q, state_d;
  logic   resp_q, resp_d;  // clearing pass owes a response

  // Only the idle state takes a request
  assign in_stall_o = (state_q != StIdle);

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    resp_d  = resp_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = resp_q ? StClrRsp : StIdle;
        end
      end
      StClrRsp: begin
        if (status_i.out_free) begin
          cmd_o.clr_rsp = 1'b1;
          resp_d        = 1'b0;
          state_d       = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        priority if (status_i.is_clear) begin
          cmd_o.clr_start = 1'b1;
          resp_d          = 1'b1;
          state_d         = StClear;
        end else if (status_i.alloc_freed) begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScanRd;
        end else if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      StScanRd: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = StScanChk;
      end
      StScanChk: begin
        if (status_i.scan_hit) begin
          if (status_i.out_free) begin
            cmd_o.scan_take = 1'b1;
            state_d         = StIdle;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = StScanRd;
        end
      end
    endcase
  end

  // State register; reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  // A request is only taken when the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (state_q == StIdle) && in_valid_i)
    else $error("request captured outside idle");

  // The clear response is given only after a clear-all request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_rsp |-> resp_q)
    else $error("clear response without clear request");

  // A scan starts only from request execution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |-> $past(cmd_o.capture) || $past(state_q == StExec))
    else $error("scan started without a pending allocate");

endmodule

/* rtl/ria_dp.sv */
// Datapath of the identifier allocator: entry memory (live, freed, count),
// fresh/freed bookkeeping registers and the response register.
// Depends on ria_pkg; driven by ria_ctrl commands.
module ria_dp #(
  parameter int ID_BITS    = ria_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = ria_pkg::DEF_COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ria_pkg::ctrl_cmd_t   cmd_i,
  output ria_pkg::dp_status_t  status_o,
  input  ria_pkg::req_t        in_req_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output ria_pkg::rsp_t        out_rsp_o
);

  localparam int ID_SPACE = 2 ** ID_BITS;
  localparam int ENTRY_W  = COUNT_BITS + 2;
  localparam int LIVE_BIT = COUNT_BITS + 1;
  localparam int FREE_BIT = COUNT_BITS;
  localparam int ID_WIDE  = (ID_BITS > ria_pkg::ID_W) ? ID_BITS : ria_pkg::ID_W;
  localparam int CNT_WIDE = (COUNT_BITS > ria_pkg::CNT_W) ? COUNT_BITS : ria_pkg::CNT_W;

  localparam logic [ID_BITS-1:0]    ID_MAX    = '1;
  localparam logic [ID_BITS-1:0]    ID_FIRST  = ID_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_INIT  = COUNT_BITS'(1);
  localparam logic [ENTRY_W-1:0]    ENT_NEW   = {2'b10, CNT_INIT};
  localparam logic [ENTRY_W-1:0]    ENT_FREED = {2'b01, {COUNT_BITS{1'b0}}};

  // Entry memory and its registered read port
  logic [ENTRY_W-1:0] entry_mem [ID_SPACE];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we, mem_re;
  logic [ID_BITS-1:0] mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Bookkeeping registers
  logic [ID_BITS-1:0] nf_q, nf_d;      // next fresh id, 0 when exhausted
  logic [ID_BITS-1:0] ft_q, ft_d;      // number of freed ids
  logic [ID_BITS-1:0] hint_q, hint_d;  // lower bound of the freed ids
  logic [ID_BITS-1:0] scan_q, scan_d;
  logic [ID_BITS-1:0] clr_q, clr_d;
  ria_pkg::req_t      req_q;

  // Response register
  logic          out_valid_q, out_valid_d;
  ria_pkg::rsp_t out_q, rsp_d;
  logic          load;

  // Request decode
  logic [ID_WIDE-1:0]    raw_ext, in_ext;
  logic                  raw_zero, known, live;
  logic [ID_BITS-1:0]    idx;
  logic [COUNT_BITS-1:0] rd_cnt;

  // Response pieces
  logic [ria_pkg::STATUS_W-1:0] st;
  logic [ID_BITS-1:0]           got;
  logic                         pres;
  logic [COUNT_BITS-1:0]        cnt;
  logic [ID_WIDE-1:0]           got_ext;
  logic [CNT_WIDE-1:0]          cnt_ext;

  assign raw_ext  = ID_WIDE'(req_q.id);
  assign in_ext   = ID_WIDE'(in_req_i.id);
  assign raw_zero = (req_q.id == '0);
  assign known    = !raw_zero && ((raw_ext >> ID_BITS) == '0);
  assign idx      = raw_ext[ID_BITS-1:0];
  assign live     = known && rd_q[LIVE_BIT];
  assign rd_cnt   = rd_q[COUNT_BITS-1:0];

  // Status to the controller
  assign status_o.alloc_freed = (req_q.kind == ria_pkg::KIND_ALLOC) && (ft_q != '0);
  assign status_o.is_clear    = (req_q.kind == ria_pkg::KIND_CLEAR);
  assign status_o.scan_hit    = rd_q[FREE_BIT];
  assign status_o.clr_last    = (clr_q == ID_MAX);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // Operation logic
  always_comb begin
    nf_d      = nf_q;
    ft_d      = ft_q;
    hint_d    = hint_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    st        = ria_pkg::ST_OK;
    got       = '0;
    pres      = 1'b0;
    cnt       = '0;

    // read port: request entry or scan entry
    if (cmd_i.capture) begin
      mem_re    = 1'b1;
      mem_raddr = in_ext[ID_BITS-1:0];
    end else if (cmd_i.scan_rd) begin
      mem_re    = 1'b1;
      mem_raddr = scan_q;
    end

    if (cmd_i.scan_start) begin
      scan_d = hint_q;
    end
    if (cmd_i.scan_next) begin
      scan_d = scan_q + ID_FIRST;
    end

    // reuse the smallest freed id
    if (cmd_i.scan_take) begin
      mem_we    = 1'b1;
      mem_waddr = scan_q;
      mem_wdata = ENT_NEW;
      got       = scan_q;
      ft_d      = ft_q - ID_FIRST;
      hint_d    = (scan_q == ID_MAX) ? ID_MAX : scan_q + ID_FIRST;
    end

    // clearing pass
    if (cmd_i.clr_start) begin
      nf_d   = ID_FIRST;
      ft_d   = '0;
      hint_d = ID_MAX;
      clr_d  = '0;
    end
    if (cmd_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
      clr_d     = clr_q + ID_FIRST;
    end

    // single-entry read-modify-write operations
    if (cmd_i.exec) begin
      unique case (req_q.kind)
        ria_pkg::KIND_ALLOC: begin
          if (nf_q != '0) begin
            mem_we    = 1'b1;
            mem_waddr = nf_q;
            mem_wdata = ENT_NEW;
            got       = nf_q;
            nf_d      = nf_q + ID_FIRST;
          end else begin
            st = ria_pkg::ST_FULL;
          end
        end
        ria_pkg::KIND_INC: begin
          if (raw_zero) begin
            st = ria_pkg::ST_INVALID;
          end else if (!live) begin
            st = ria_pkg::ST_NOT_FOUND;
          end else if (rd_cnt == CNT_MAX) begin
            st = ria_pkg::ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx;
            mem_wdata = {2'b10, rd_cnt + CNT_INIT};
          end
        end
        ria_pkg::KIND_DEC: begin
          if (raw_zero) begin
            st = ria_pkg::ST_INVALID;
          end else if (!live) begin
            st = ria_pkg::ST_NOT_FOUND;
          end else if (rd_cnt <= CNT_INIT) begin
            // last reference: move to the freed set
            mem_we    = 1'b1;
            mem_waddr = idx;
            mem_wdata = ENT_FREED;
            ft_d      = ft_q + ID_FIRST;
            hint_d    = (idx < hint_q) ? idx : hint_q;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx;
            mem_wdata = {2'b10, rd_cnt - CNT_INIT};
          end
        end
        ria_pkg::KIND_QUERY: begin
          if (raw_zero) begin
            st = ria_pkg::ST_INVALID;
          end else if (live) begin
            pres = 1'b1;
            cnt  = rd_cnt;
          end
        end
        default: begin
        end
      endcase
    end

    got_ext           = ID_WIDE'(got);
    cnt_ext           = CNT_WIDE'(cnt);
    rsp_d.status      = st;
    rsp_d.new_id      = got_ext[ria_pkg::ID_W-1:0];
    rsp_d.present     = pres;
    rsp_d.ref_count   = cnt_ext[ria_pkg::CNT_W-1:0];
    rsp_d.is_full     = (nf_d == '0) && (ft_d == '0);
  end

  // Response register handshake
  assign load = cmd_i.exec | cmd_i.scan_take | cmd_i.clr_rsp;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q        <= ID_FIRST;
      ft_q        <= '0;
      hint_q      <= ID_MAX;
      scan_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      nf_q        <= nf_d;
      ft_q        <= ft_d;
      hint_q      <= hint_d;
      scan_q      <= scan_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
    if (load) begin
      out_q <= rsp_d;
    end
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= entry_mem[mem_raddr];
    end
  end

  // The response register is never overwritten while a word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_q || !out_stall_i)
    else $error("response overwritten while stalled");

  // A scan only runs while a freed id exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> ft_q != '0)
    else $error("freed-id scan with no freed id");

  // A reused id was freed and not live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_take |-> rd_q[FREE_BIT] && !rd_q[LIVE_BIT])
    else $error("scan handed out an id that was not freed");

  // Counts are reported only for live ids
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.present |-> out_q.ref_count == '0)
    else $error("count reported without presence");

endmodule

/* rtl/refcounted_id_allocator.sv */
// Top level of the reference-counted identifier allocator.
// Joins ria_ctrl and ria_dp; types and codes come from ria_pkg.
//
// Hands out identifiers 1 .. 2^ID_BITS-1 with a reference count per live id.
// One request word is taken at a time; increment, decrement, query and an
// allocate of a fresh id first read the entry, then do a read-modify-write of
// the entry memory. An allocate that reuses a freed id scans that
// memory upward from a lower bound on the smallest freed id, reading and then
// checking each entry looked at. Clear-all and reset run a clearing pass
// over every entry, 2^ID_BITS entries (256 at the default), and take no
// request meanwhile; a clear-all adds steps around it (request capture,
// decode and the response load).
// The response sits in an output register, so the next request is taken while
// a response still waits on out_stall_i.
module refcounted_id_allocator #(
  parameter int ID_BITS    = ria_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = ria_pkg::DEF_COUNT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ria_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ria_pkg::rsp_t out_rsp_o
);

  ria_pkg::ctrl_cmd_t  cmd;
  ria_pkg::dp_status_t status;

  // Sequencer
  ria_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Entry memory, bookkeeping and response
  ria_dp #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
